FILE: hdl/stream_suffix_pattern_matcher_assert.svh
// Assertion macros for the checker of the suffix matcher.
`ifndef STREAM_SUFFIX_PATTERN_MATCHER_ASSERT_SVH
`define STREAM_SUFFIX_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define SSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define SSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ssm_pkg.sv
// Package: sizes, mode codes and control structs of the suffix matcher.
`timescale 1ns / 1ps
package ssm_pkg;

  localparam int MAX_WORDS = 16;
  localparam int MAX_LEN   = 16;

  localparam int MODE_W = 2;
  localparam int SLOT_W = 4;
  localparam int POS_W  = 4;
  localparam int SYM_W  = 8;

  localparam int WORD_IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int HIST_IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int ROW_W      = MAX_LEN * SYM_W;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_LOAD   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_STREAM = MODE_W'(2);

  typedef struct packed {
    logic clear;        // drop all patterns
    logic load_rd;      // capture load item, read its row
    logic load_wr;      // write merged row, set length on final symbol
    logic stream_take;  // shift symbol into history, restart scan
    logic scan_step;    // read next row for comparison
    logic out_load;     // move hit flag into output register
  } ssm_cmd_t;

  typedef struct packed {
    logic load_ok;      // slot and position inside the table
    logic scan_last;    // scan counter on last row
    logic out_busy;     // output register full and stalled
  } ssm_status_t;

endpackage

FILE: hdl/ssm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/ssm_ctrl.sv
// Controller: sequences clear, load and stream items over the datapath.
`timescale 1ns / 1ps
module ssm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [ssm_pkg::MODE_W-1:0]   mode,
  input  ssm_pkg::ssm_status_t         status,
  output logic                         in_stall,
  output ssm_pkg::ssm_cmd_t            cmd
);
  import ssm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_LOAD_WR  = 5'b00010,
    S_SCAN     = 5'b00100,
    S_SCAN_END = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            MODE_LOAD: begin
              if (status.load_ok) begin
                cmd.load_rd = 1'b1;
                state_next  = S_LOAD_WR;
              end
            end
            MODE_STREAM: begin
              cmd.stream_take = 1'b1;
              state_next      = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last row is compared in this cycle
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/ssm_datapath.sv
// Datapath: pattern RAM, lengths, history, row comparator, output register.
`timescale 1ns / 1ps
module ssm_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  ssm_pkg::ssm_cmd_t           cmd,
  output ssm_pkg::ssm_status_t        status,
  input  logic [ssm_pkg::SLOT_W-1:0]  slot,
  input  logic [ssm_pkg::POS_W-1:0]   position,
  input  logic [ssm_pkg::SYM_W-1:0]   symbol,
  input  logic                        final_symbol,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        matched
);
  import ssm_pkg::*;

  logic [SYM_W-1:0]      history [MAX_LEN];
  logic [LEN_W-1:0]      hist_fill;
  logic [LEN_W-1:0]      pat_len [MAX_WORDS];
  logic [MAX_WORDS-1:0]  pat_valid;

  logic [WORD_IDX_W-1:0] ld_slot;
  logic [HIST_IDX_W-1:0] ld_pos;
  logic [SYM_W-1:0]      ld_sym;
  logic                  ld_fin;

  logic [WORD_IDX_W-1:0] scan_cnt;
  logic [WORD_IDX_W-1:0] cmp_idx;
  logic                  cmp_pending;
  logic                  hit;

  logic                  ram_re;
  logic [WORD_IDX_W-1:0] ram_raddr;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      wr_row;

  logic [LEN_W-1:0]      cur_len;
  logic [LEN_W-1:0]      dk;
  logic                  row_hit;

  assign status.load_ok   = (int'(slot) < MAX_WORDS) && (int'(position) < MAX_LEN);
  assign status.scan_last = (scan_cnt == WORD_IDX_W'(MAX_WORDS - 1));
  assign status.out_busy  = out_valid && out_stall;

  assign ram_re    = cmd.load_rd || cmd.scan_step;
  assign ram_raddr = cmd.load_rd ? WORD_IDX_W'(slot) : scan_cnt;

  ssm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (ld_slot),
    .wdata (wr_row),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read-modify-write: replace one symbol of the row
  always_comb begin
    wr_row = ram_rdata;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (HIST_IDX_W'(k) == ld_pos) begin
        wr_row[k*SYM_W +: SYM_W] = ld_sym;
      end
    end
  end

  // pattern symbol k lines up with history entry len-1-k
  always_comb begin
    cur_len = pat_len[cmp_idx];
    dk      = '0;
    row_hit = pat_valid[cmp_idx] && (cur_len != '0) && (cur_len <= hist_fill);
    for (int k = 0; k < MAX_LEN; k++) begin
      if (LEN_W'(k) < cur_len) begin
        dk = cur_len - LEN_W'(k) - LEN_W'(1);
        if (ram_rdata[k*SYM_W +: SYM_W] != history[dk[HIST_IDX_W-1:0]]) begin
          row_hit = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_fill   <= '0;
      pat_valid   <= '0;
      scan_cnt    <= '0;
      cmp_pending <= 1'b0;
      hit         <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < MAX_WORDS; i++) begin
        pat_len[i] <= '0;
      end
      for (int i = 0; i < MAX_LEN; i++) begin
        history[i] <= '0;
      end
    end else begin
      cmp_pending <= cmd.scan_step;

      if (cmd.clear) begin
        pat_valid <= '0;
        for (int i = 0; i < MAX_WORDS; i++) begin
          pat_len[i] <= '0;
        end
      end

      if (cmd.load_wr && ld_fin) begin
        pat_len[ld_slot]   <= LEN_W'(ld_pos) + LEN_W'(1);
        pat_valid[ld_slot] <= 1'b1;
      end

      if (cmd.stream_take) begin
        history[0] <= symbol;
        for (int i = 1; i < MAX_LEN; i++) begin
          history[i] <= history[i-1];
        end
        if (hist_fill != LEN_W'(MAX_LEN)) begin
          hist_fill <= hist_fill + LEN_W'(1);
        end
        scan_cnt <= '0;
        hit      <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_cnt <= scan_cnt + WORD_IDX_W'(1);
        end
        if (cmp_pending && row_hit) begin
          hit <= 1'b1;
        end
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      ld_slot <= WORD_IDX_W'(slot);
      ld_pos  <= HIST_IDX_W'(position);
      ld_sym  <= symbol;
      ld_fin  <= final_symbol;
    end
    if (cmd.scan_step) begin
      cmp_idx <= scan_cnt;
    end
    if (cmd.out_load) begin
      matched <= hit;
    end
  end

endmodule

FILE: hdl/stream_suffix_pattern_matcher.sv
// Top level of the multi-pattern stream suffix matcher.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, mode, slot, position,      | sink
//          | symbol, final_symbol                           |
//  out     | out_valid, out_stall, matched                  | source
//
// Clear items and out-of-range loads are done without leaving the idle state; a
// load reads the pattern row, then writes it back with one symbol replaced.
// A stream item reads one row of the pattern RAM per cycle through its single
// read port and compares each row against the whole history in parallel.
// rst is synchronous: it empties the table and the history, drops any result.
// A stalled result waits in the output register; the next item is taken
// meanwhile, and a following stream item waits at its end for the register.
`timescale 1ns / 1ps
module stream_suffix_pattern_matcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ssm_pkg::MODE_W-1:0]  mode,
  input  logic [ssm_pkg::SLOT_W-1:0]  slot,
  input  logic [ssm_pkg::POS_W-1:0]   position,
  input  logic [ssm_pkg::SYM_W-1:0]   symbol,
  input  logic                        final_symbol,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        matched
);
  import ssm_pkg::*;

  // controller <-> datapath
  ssm_cmd_t    cmd;
  ssm_status_t status;

  ssm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // pattern rows live in RAM; lengths, valid bits and history in flops
  ssm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .slot         (slot),
    .position     (position),
    .symbol       (symbol),
    .final_symbol (final_symbol),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .matched      (matched)
  );

endmodule

FILE: hdl/ssm_checker.sv
// Port-level checker for the suffix matcher, bound to the top level.
`timescale 1ns / 1ps
`include "stream_suffix_pattern_matcher_assert.svh"
module ssm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [ssm_pkg::MODE_W-1:0]  mode,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        matched
);
  import ssm_pkg::*;

  `SSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(matched), "stalled result changed")
  `SSM_ASSERT_NEXT(a_stream_busy, in_valid && !in_stall && (mode == MODE_STREAM), in_stall, "stream item did not occupy the block")
  `SSM_ASSERT_NEXT(a_no_result, in_valid && !in_stall && (mode != MODE_STREAM), !$rose(out_valid), "result without a stream item")
  `SSM_ASSERT_NOW(a_result_after_scan, $rose(out_valid), $past(in_stall), "result appeared outside a scan")

endmodule

bind stream_suffix_pattern_matcher ssm_checker u_ssm_checker (.*);

FILE: tb/testbench.sv
// Testbench for the suffix matcher: directed and random items, checked against a local model.
`timescale 1ns / 1ps
module testbench;

  import ssm_pkg::*;

  // Mode 3 has no name in the package; the block must ignore it.
  localparam logic [MODE_W-1:0] MODE_RESERVED = MODE_W'(3);

  localparam int ITEM_TARGET    = 650;   // accepted items that stop the random part
  localparam int LONG_HOLD      = 150;   // receiver hold-off that fills the block
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES   = 40;    // wait after the last owed result, watching for strays

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input channel.
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode         = MODE_CLEAR;
  logic [SLOT_W-1:0] slot         = '0;
  logic [POS_W-1:0]  position     = '0;
  logic [SYM_W-1:0]  symbol       = '0;
  logic              final_symbol = 1'b0;

  // Output channel.
  logic out_valid;
  logic out_stall = 1'b0;
  logic matched;

  stream_suffix_pattern_matcher u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .slot         (slot),
    .position     (position),
    .symbol       (symbol),
    .final_symbol (final_symbol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .matched      (matched)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Matcher model: pattern table, stream history and the queue of match flags
  // still owed by the block, one per accepted stream item.
  // ---------------------------------------------------------------------------
  bit [SYM_W-1:0] pat_sym     [MAX_WORDS][MAX_LEN];
  bit             sym_written [MAX_WORDS][MAX_LEN];  // not cleared by clear items
  int             pat_len     [MAX_WORDS];
  bit             pat_live    [MAX_WORDS];
  bit [SYM_W-1:0] hist        [MAX_LEN];             // index 0 is the newest symbol
  int             hist_fill;
  bit             expected_hits [$];

  int  errors      = 0;
  int  item_count  = 0;    // accepted items, ignored mode left out
  bit  tx_gaps     = 1'b0; // sender idles at random
  bit  rx_gaps     = 1'b0; // receiver stalls at random
  int  holds_asked = 0;    // bumped to request one long receiver hold-off
  logic [SYM_W-1:0] alphabet [3];

  // Apply one accepted item to the model; a stream item owes one match flag.
  task automatic model_item(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                            input logic [POS_W-1:0] p, input logic [SYM_W-1:0] sym,
                            input logic fin);
    bit hit;
    bit same;
    int len;
    hit = 1'b0;
    case (m)
      MODE_CLEAR: begin
        // lengths and valid bits only; symbols and history survive
        for (int w = 0; w < MAX_WORDS; w++) begin
          pat_len[w]  = 0;
          pat_live[w] = 1'b0;
        end
      end
      MODE_LOAD: begin
        if (int'(s) < MAX_WORDS && int'(p) < MAX_LEN) begin
          pat_sym[s][p]     = sym;
          sym_written[s][p] = 1'b1;
          if (fin) begin
            pat_len[s]  = int'(p) + 1;
            pat_live[s] = 1'b1;
          end
        end
      end
      MODE_STREAM: begin
        for (int k = MAX_LEN - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = sym;
        if (hist_fill < MAX_LEN) hist_fill++;
        // pattern position 0 lines up with the oldest of the newest len symbols
        for (int w = 0; w < MAX_WORDS; w++) begin
          len = pat_len[w];
          if (pat_live[w] && len != 0 && len <= hist_fill) begin
            same = 1'b1;
            for (int k = 0; k < len; k++)
              if (pat_sym[w][k] != hist[len-1-k]) same = 1'b0;
            if (same) hit = 1'b1;
          end
        end
        expected_hits = {expected_hits, hit};
      end
      default: ;
    endcase
  endtask

  // Gap length: mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly symbols of the current alphabet so that patterns do hit.
  function automatic int next_symbol();
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, 255);
    return int'(alphabet[$urandom_range(0, 2)]);
  endfunction

  // Offer one item, hold it until accepted, then update the model.
  task automatic send_item(input logic [MODE_W-1:0] m, input int s, input int p,
                           input int sym, input int fin);
    int gap;
    logic [SLOT_W-1:0] s_w;
    logic [POS_W-1:0]  p_w;
    logic [SYM_W-1:0]  sym_w;
    logic              fin_w;
    s_w   = SLOT_W'(s);
    p_w   = POS_W'(p);
    sym_w = SYM_W'(sym);
    fin_w = 1'(fin);
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    slot         <= s_w;
    position     <= p_w;
    symbol       <= sym_w;
    final_symbol <= fin_w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_item(m, s_w, p_w, sym_w, fin_w);
    if (m != MODE_RESERVED) item_count++;
  endtask

  // Well-formed load: positions in order, final flag on the last one.
  task automatic load_random_pattern(input int s, input int len);
    for (int k = 0; k < len; k++)
      send_item(MODE_LOAD, s, k, next_symbol(), int'(k == len - 1));
  endtask

  task automatic send_stream(input int sym);
    send_item(MODE_STREAM, $urandom_range(0, 15), $urandom_range(0, 15), sym,
              $urandom_range(0, 1));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  int rx_left;
  int holds_done;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      rx_left    <= 0;
      holds_done <= 0;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      out_stall  <= 1'b1;
      rx_left    <= LONG_HOLD - 1;
    end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      rx_left   <= gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each accepted match flag against the oldest one owed.
  // ---------------------------------------------------------------------------
  bit hit_want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: result with none owed: expected nothing, actual matched=%0b",
                 $time, matched);
        errors++;
      end else begin
        hit_want = expected_hits.pop_front();
        if (matched !== hit_want) begin
          $display("%0t: matched mismatch: expected %0b, actual %0b",
                   $time, hit_want, matched);
          errors++;
        end
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long.
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the history is empty: a 3-symbol pattern of zeros must
  // not hit until three symbols have streamed in, though the history reads 0.
  // Uses the top slot.
  task automatic test_short_history();
    send_item(MODE_LOAD, 15, 0, 'h00, 0);
    send_item(MODE_LOAD, 15, 1, 'h00, 0);
    send_item(MODE_LOAD, 15, 2, 'h00, 1);
    repeat (3) send_stream('h00);
  endtask

  // One-symbol pattern at the bottom slot, all-ones symbol.
  task automatic test_single_symbol();
    send_item(MODE_LOAD, 0, 0, 'hFF, 1);
    send_stream('hFF);
  endtask

  // Mode 3 with every field at its top must leave table and history alone.
  task automatic test_unused_mode();
    send_item(MODE_RESERVED, 15, 15, 'hFF, 1);
    send_stream('hFF);
  endtask

  // Clear drops every pattern: the same symbol no longer hits.
  task automatic test_clear();
    send_item(MODE_CLEAR, 15, 15, 'hFF, 1);
    send_stream('hFF);
  endtask

  // A non-final write over a live pattern changes its symbol but keeps it live.
  task automatic test_overwrite();
    send_item(MODE_LOAD, 0, 0, 'h11, 1);
    send_item(MODE_LOAD, 0, 0, 'h22, 0);
    send_stream('h22);
  endtask

  // Receiver holds off while the sender keeps streaming: the output register
  // fills, the next stream item waits, and in_stall must back up the input.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom());
    load_random_pattern(3, 2);
    holds_asked <= holds_asked + 1;
    repeat (24) send_stream(next_symbol());
  endtask

  // Phases of: optional clear, a few pattern loads (mostly well formed, some
  // stray writes), then a stream from a small alphabet with whole live
  // patterns spliced in so that long patterns hit too, with stray mode 3 items.
  task automatic test_random_traffic();
    int  len;
    int  s;
    int  p;
    int  w;
    bit  prefix_ok;
    bit  first;
    first = 1'b1;
    while (item_count < ITEM_TARGET) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps <= ($urandom_range(0, 3) != 0);
      foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom());
      if ($urandom_range(0, 3) == 0)
        send_item(MODE_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 255), $urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) begin
        s = $urandom_range(0, MAX_WORDS - 1);
        if (first) len = MAX_LEN;
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(5, MAX_LEN);
        else len = $urandom_range(1, 4);
        first = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
          // stray write; final only where every earlier position holds data
          p = $urandom_range(0, MAX_LEN - 1);
          prefix_ok = 1'b1;
          for (int k = 0; k < p; k++)
            if (!sym_written[s][k]) prefix_ok = 1'b0;
          send_item(MODE_LOAD, s, p, next_symbol(), prefix_ok ? $urandom_range(0, 1) : 0);
        end else begin
          load_random_pattern(s, len);
        end
      end
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 4) == 0) begin
          w = $urandom_range(0, MAX_WORDS - 1);
          for (int t = 0; t < MAX_WORDS && !pat_live[w]; t++) w = (w + 1) % MAX_WORDS;
          if (pat_live[w])
            for (int k = 0; k < pat_len[w]; k++) send_stream(int'(pat_sym[w][k]));
        end else begin
          send_stream(next_symbol());
        end
        if ($urandom_range(0, 29) == 0)
          send_item(MODE_RESERVED, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 255), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_short_history();
    test_single_symbol();
    test_unused_mode();
    test_clear();
    test_overwrite();
    test_backpressure();
    test_random_traffic();

    // drain: stop offering, let every owed result arrive, then watch for strays
    in_valid <= 1'b0;
    rx_gaps  <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
